// ===== hw/rtl/midpoint_ellipse_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse rasterizer checker.
// Each macro wraps one concurrent assertion, clocked on the rising edge and
// disabled while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MER_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define MER_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== hw/rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

	localparam int COORD_WIDTH_DEF = 10;
	localparam int QUEUE_DEPTH     = 2;

	// Command codes carried in the func field.
	localparam logic FUNC_START = 1'b0;

	// Quadrant tags, also the beat order within one step.
	localparam logic [1:0] QUAD_PX_NY = 2'd0;
	localparam logic [1:0] QUAD_NX_PY = 2'd1;
	localparam logic [1:0] QUAD_PX_PY = 2'd2;
	localparam logic [1:0] QUAD_NX_NY = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ONE  = 2'd1,
		PH_TWO  = 2'd2
	} mer_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SU_RX,
		ST_SU_RY,
		ST_SU_DY,
		ST_SU_DEC,
		ST_SW_A,
		ST_SW_B,
		ST_SW_C,
		ST_SW_D,
		ST_SW_E,
		ST_SW_F,
		ST_CLASS,
		ST_ADD,
		ST_SUB
	} mer_front_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mer_fifo_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mer_if.sv =====
// ----------------------------------------------------------------------------
// mer_if
// Valid/ready channels of the rasterizer: command in, pixel out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mer_cmd_if #(
	parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic [COORD_WIDTH-1:0] center_x;
	logic [COORD_WIDTH-1:0] center_y;
	logic [COORD_WIDTH-2:0] radius_x;
	logic [COORD_WIDTH-2:0] radius_y;

	modport source (
		output valid, func, center_x, center_y, radius_x, radius_y,
		input  ready
	);
	modport sink (
		input  valid, func, center_x, center_y, radius_x, radius_y,
		output ready
	);
endinterface

interface mer_pix_if #(
	parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH+1:0] pixel_x;
	logic signed [COORD_WIDTH+1:0] pixel_y;
	logic [1:0]                    quadrant;
	logic                          last_of_step;
	logic                          finished;

	modport source (
		output valid, pixel_x, pixel_y, quadrant, last_of_step, finished,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, quadrant, last_of_step, finished,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Two-region midpoint ellipse rasterizer with a command front, a short job
// queue and a pixel back end.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the cmd channel. A start beat (func 0) latches
// the centre and both radii and prepares the first point; it produces no
// pixels. Each step beat (func 1) produces four pixel beats on the pixel
// channel, tagged with their quadrant, the fourth carrying last_of_step. The
// step taken at y zero in region two marks its four beats finished and the
// block returns to idle, where further step beats are taken and dropped.
// A step passes the classify state, the job queue and the back end's
// registers before its first pixel is offered. A start occupies the command
// side for accepting, three products on the shared multiplier and a state
// that forms the decision. An ordinary step holds the command side for the
// accept, classify, add and subtract states. The step that crosses into
// region two first spends the switch states on the shared multiplier.
// Reset clears the sequencer, the ellipse phase, the queue and the output
// stage; no pixel is offered until a start and a step have been taken.
// When the receiver stalls, the current beat holds; the queue fills, and
// then the command side stops taking beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer #(
	parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mer_cmd_if.sink    cmd,
	mer_pix_if.source  pixel
);

	// One queued job: centre, point and the finished flag, packed as
	// {centre x, centre y, point x, point y, finished}.
	localparam int JOB_W = 4 * COORD_WIDTH;

	logic                    push;
	logic [JOB_W-1:0]        push_data;
	logic                    pop;
	logic [JOB_W-1:0]        pop_data;
	mer_pkg::mer_fifo_stat_t q_stat;

	// The front owns the decision walk; it only pushes a job once the queue
	// has room, so a stalled receiver simply parks it in its classify state.
	mer_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.push     (push),
		.push_data(push_data),
		.q_stat   (q_stat)
	);

	// Jobs carry their own centre, so a new start may be set up while the
	// back end is still sending the previous ellipse's last pixels.
	mer_fifo #(
		.DATA_W(JOB_W),
		.DEPTH (mer_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (q_stat)
	);

	// The back end reloads on the cycle its fourth beat goes out, so queued steps
	// follow each other on the pixel channel without a gap.
	mer_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop     (pop),
		.pop_data(pop_data),
		.q_stat  (q_stat),
		.pixel   (pixel)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mer_fifo.sv =====
// ----------------------------------------------------------------------------
// mer_fifo
// Short first-in first-out queue carrying pixel jobs from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_fifo #(
	parameter int DATA_W = 40,
	parameter int DEPTH  = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [DATA_W-1:0]     push_data,
	input  wire logic                  pop,
	output logic [DATA_W-1:0]          pop_data,
	output mer_pkg::mer_fifo_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mer_front.sv =====
// ----------------------------------------------------------------------------
// mer_front
// Command side: takes start and step beats, runs the set-up and region-switch
// products on one shared multiplier, and walks the midpoint decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_front #(
	parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	mer_cmd_if.sink                        cmd,
	output logic                           push,
	output logic [4*COORD_WIDTH-1:0]       push_data,
	input  wire mer_pkg::mer_fifo_stat_t   q_stat
);

	localparam int CW   = COORD_WIDTH;
	localparam int RW   = CW - 1;
	localparam int R2_W = 2 * RW;
	localparam int SW   = 3 * CW;
	localparam int MA_W = 2 * CW - 2;
	localparam int MB_W = 2 * CW + 2;
	localparam int PW   = MA_W + MB_W;
	localparam int DW   = (4 * CW + 4 > 64) ? 64 : 4 * CW + 4;
	localparam int K_W  = R2_W + 4;
	localparam int T_W  = SW + 4;

	mer_pkg::mer_front_state_t state_q, state_d;
	mer_pkg::mer_phase_t       phase_q, phase_d;

	logic [CW-1:0]   cx_q, cy_q, x_q;
	logic [RW-1:0]   rx_q, ry_q, y_q;
	logic [R2_W-1:0] rx2_q, ry2_q;
	logic [K_W-1:0]  c12ry2_q, k2_q;
	logic [SW-1:0]   sdx_q, sdy_q;
	logic [DW-1:0]   dec_q;
	logic [MB_W-1:0] tmp_q;
	logic [PW-1:0]   prod_q;
	logic [T_W-1:0]  t_q;
	logic            sub_q;

	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [PW-1:0]   prod_d;
	logic [CW:0]     a_term;
	logic [RW-1:0]   b_term;
	logic            dec_neg, dec_pos, region_one, adv_x, adv_y, fin, accept;
	logic [K_W-1:0]  k_sel;
	logic [T_W-1:0]  t_d;

	assign cmd.ready  = (state_q == mer_pkg::ST_IDLE);
	assign accept     = cmd.valid && cmd.ready;

	assign a_term     = {x_q, 1'b1};
	assign b_term     = (y_q == '0) ? RW'(1) : y_q - RW'(1);
	assign dec_neg    = dec_q[DW-1];
	assign dec_pos    = !dec_neg && (dec_q != '0);
	assign region_one = (phase_q == mer_pkg::PH_ONE);
	assign fin        = (phase_q == mer_pkg::PH_TWO) && (y_q == '0);

	// Region one always moves x and moves y on a non-negative decision;
	// region two always moves y and moves x unless the decision is positive.
	assign adv_x = region_one ? 1'b1 : !dec_pos;
	assign adv_y = region_one ? !dec_neg : 1'b1;
	assign k_sel = region_one ? c12ry2_q : (dec_pos ? (K_W'(rx2_q) << 2) : k2_q);
	assign t_d   = (adv_x ? (T_W'(sdx_q) << 3) : '0) + T_W'(k_sel);

	assign push_data = {cx_q, cy_q, x_q, y_q, fin};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			mer_pkg::ST_SU_RX: begin
				mul_a = MA_W'(rx_q);
				mul_b = MB_W'(rx_q);
			end
			mer_pkg::ST_SU_RY: begin
				mul_a = MA_W'(ry_q);
				mul_b = MB_W'(ry_q);
			end
			mer_pkg::ST_SU_DY: begin
				mul_a = MA_W'(rx2_q);
				mul_b = MB_W'(ry_q);
			end
			mer_pkg::ST_SW_A: begin
				mul_a = MA_W'(a_term);
				mul_b = MB_W'(a_term);
			end
			mer_pkg::ST_SW_B: begin
				mul_a = MA_W'(b_term);
				mul_b = MB_W'(b_term);
			end
			mer_pkg::ST_SW_C: begin
				mul_a = MA_W'(rx2_q);
				mul_b = prod_q[MB_W-1:0];
			end
			mer_pkg::ST_SW_D: begin
				mul_a = MA_W'(ry2_q);
				mul_b = tmp_q;
			end
			mer_pkg::ST_SW_E: begin
				mul_a = MA_W'(rx2_q);
				mul_b = MB_W'(ry2_q);
			end
			default: begin
			end
		endcase
	end

	assign prod_d = PW'(mul_a) * PW'(mul_b);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		push    = 1'b0;
		unique case (state_q)
			mer_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd.func == mer_pkg::FUNC_START) begin
						state_d = mer_pkg::ST_SU_RX;
					end else if (phase_q == mer_pkg::PH_IDLE) begin
						state_d = mer_pkg::ST_IDLE;
					end else if (region_one && !(sdx_q < sdy_q)) begin
						state_d = mer_pkg::ST_SW_A;
					end else begin
						state_d = mer_pkg::ST_CLASS;
					end
				end
			end
			mer_pkg::ST_SU_RX:  state_d = mer_pkg::ST_SU_RY;
			mer_pkg::ST_SU_RY:  state_d = mer_pkg::ST_SU_DY;
			mer_pkg::ST_SU_DY:  state_d = mer_pkg::ST_SU_DEC;
			mer_pkg::ST_SU_DEC: begin
				phase_d = mer_pkg::PH_ONE;
				state_d = mer_pkg::ST_IDLE;
			end
			mer_pkg::ST_SW_A:   state_d = mer_pkg::ST_SW_B;
			mer_pkg::ST_SW_B:   state_d = mer_pkg::ST_SW_C;
			mer_pkg::ST_SW_C:   state_d = mer_pkg::ST_SW_D;
			mer_pkg::ST_SW_D:   state_d = mer_pkg::ST_SW_E;
			mer_pkg::ST_SW_E:   state_d = mer_pkg::ST_SW_F;
			mer_pkg::ST_SW_F: begin
				phase_d = mer_pkg::PH_TWO;
				state_d = mer_pkg::ST_CLASS;
			end
			mer_pkg::ST_CLASS: begin
				if (!q_stat.full) begin
					push = 1'b1;
					if (fin) begin
						phase_d = mer_pkg::PH_IDLE;
						state_d = mer_pkg::ST_IDLE;
					end else begin
						state_d = mer_pkg::ST_ADD;
					end
				end
			end
			mer_pkg::ST_ADD:    state_d = mer_pkg::ST_SUB;
			mer_pkg::ST_SUB:    state_d = mer_pkg::ST_IDLE;
			default:            state_d = mer_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_IDLE;
			phase_q <= mer_pkg::PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Datapath. The product register sits after the multiplier, so each
	// state consumes the product that the previous state asked for.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		unique case (state_q)
			mer_pkg::ST_IDLE: begin
				if (accept && cmd.func == mer_pkg::FUNC_START) begin
					cx_q  <= cmd.center_x;
					cy_q  <= cmd.center_y;
					rx_q  <= cmd.radius_x;
					ry_q  <= cmd.radius_y;
					x_q   <= '0;
					y_q   <= cmd.radius_y;
					sdx_q <= '0;
				end
			end
			mer_pkg::ST_SU_RY: rx2_q <= prod_q[R2_W-1:0];
			mer_pkg::ST_SU_DY: begin
				ry2_q <= prod_q[R2_W-1:0];
				dec_q <= (DW'(prod_q) << 2) + DW'(rx2_q);
			end
			mer_pkg::ST_SU_DEC: begin
				sdy_q    <= SW'(prod_q);
				dec_q    <= dec_q - (DW'(prod_q) << 2);
				c12ry2_q <= (K_W'(ry2_q) << 3) + (K_W'(ry2_q) << 2);
				k2_q     <= (K_W'(ry2_q) << 3) + (K_W'(rx2_q) << 2);
			end
			mer_pkg::ST_SW_B: tmp_q <= prod_q[MB_W-1:0];
			mer_pkg::ST_SW_D: dec_q <= DW'(prod_q) << 2;
			mer_pkg::ST_SW_E: dec_q <= dec_q + DW'(prod_q);
			mer_pkg::ST_SW_F: dec_q <= dec_q - (DW'(prod_q) << 2);
			mer_pkg::ST_CLASS: begin
				if (!q_stat.full && !fin) begin
					if (adv_x) begin
						x_q   <= x_q + CW'(1);
						sdx_q <= sdx_q + SW'(ry2_q);
					end
					if (adv_y) begin
						y_q   <= y_q - RW'(1);
						sdy_q <= sdy_q - SW'(rx2_q);
					end
					t_q   <= t_d;
					sub_q <= adv_y;
				end
			end
			mer_pkg::ST_ADD: dec_q <= dec_q + DW'(t_q);
			mer_pkg::ST_SUB: begin
				if (sub_q) begin
					dec_q <= dec_q - (DW'(sdy_q) << 3);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mer_back.sv =====
// ----------------------------------------------------------------------------
// mer_back
// Pixel side: takes one job from the queue and sends its four mirrored
// pixels, one beat per cycle while the receiver is ready, from registered state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_back #(
	parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	output logic                           pop,
	input  wire logic [4*COORD_WIDTH-1:0]  pop_data,
	input  wire mer_pkg::mer_fifo_stat_t   q_stat,
	mer_pix_if.source                      pixel
);

	localparam int CW  = COORD_WIDTH;
	localparam int RW  = CW - 1;
	localparam int EW  = 4 * CW;
	localparam int PXW = CW + 2;

	logic [EW-1:0]  cur_q;
	logic           busy_q;
	logic [1:0]     cnt_q;
	logic           fire, done;
	logic [CW-1:0]  cx, cy, px;
	logic [RW-1:0]  py;
	logic [PXW-1:0] x_plus, x_minus, y_plus, y_minus;
	logic [PXW-1:0] sel_x, sel_y;

	assign cx = cur_q[EW-1 -: CW];
	assign cy = cur_q[EW-CW-1 -: CW];
	assign px = cur_q[EW-2*CW-1 -: CW];
	assign py = cur_q[RW:1];

	assign x_plus  = PXW'(cx) + PXW'(px);
	assign x_minus = PXW'(cx) - PXW'(px);
	assign y_plus  = PXW'(cy) + PXW'(py);
	assign y_minus = PXW'(cy) - PXW'(py);

	always_comb begin
		unique case (cnt_q)
			mer_pkg::QUAD_PX_NY: begin
				sel_x = x_plus;
				sel_y = y_minus;
			end
			mer_pkg::QUAD_NX_PY: begin
				sel_x = x_minus;
				sel_y = y_plus;
			end
			mer_pkg::QUAD_PX_PY: begin
				sel_x = x_plus;
				sel_y = y_plus;
			end
			default: begin
				sel_x = x_minus;
				sel_y = y_minus;
			end
		endcase
	end

	assign pixel.valid        = busy_q;
	assign pixel.pixel_x      = $signed(sel_x);
	assign pixel.pixel_y      = $signed(sel_y);
	assign pixel.quadrant     = cnt_q;
	assign pixel.last_of_step = (cnt_q == mer_pkg::QUAD_NX_NY);
	assign pixel.finished     = cur_q[0];

	assign fire = pixel.valid && pixel.ready;
	assign done = fire && (cnt_q == mer_pkg::QUAD_NX_NY);
	assign pop  = !q_stat.empty && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= mer_pkg::QUAD_PX_NY;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q  <= mer_pkg::QUAD_PX_NY;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker
// Port-level checks on the pixel channel of the rasterizer, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_checker #(
	parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   pix_valid,
	input wire logic                   pix_ready,
	input wire logic [COORD_WIDTH+1:0] pixel_x,
	input wire logic [1:0]             quadrant,
	input wire logic                   last_of_step,
	input wire logic                   finished
);

	// A stalled beat stays offered with the same column.
	`MER_ASSERT_NEXT(a_stall_hold, clk, arst_n, pix_valid && !pix_ready, pix_valid && $stable(pixel_x))

	// Only the fourth quadrant closes a step.
	`MER_ASSERT_IMP(a_last_on_final_quad, clk, arst_n, pix_valid, last_of_step == (quadrant == mer_pkg::QUAD_NX_NY))

	// Within a step the four beats follow back to back in quadrant order.
	`MER_ASSERT_NEXT(a_step_in_order, clk, arst_n, pix_valid && pix_ready && !last_of_step, pix_valid && (quadrant == 2'($past(quadrant) + 2'd1)))

	// The finished flag is the same on all four beats of a step.
	`MER_ASSERT_NEXT(a_finish_steady, clk, arst_n, pix_valid && pix_ready && !last_of_step, finished == $past(finished))

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_mer_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pix_valid   (pixel.valid),
	.pix_ready   (pixel.ready),
	.pixel_x     (pixel.pixel_x),
	.quadrant    (pixel.quadrant),
	.last_of_step(pixel.last_of_step),
	.finished    (pixel.finished)
);

`default_nettype wire

// ===== test/midpoint_ellipse_rasterizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_test
// Self-checking testbench for the two-region midpoint ellipse rasterizer.
// Commands are pushed in over the cmd channel and the pixel stream is compared
// beat by beat with the output of a behavioural copy of the rasteriser.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_test;

	localparam int   CW               = mer_pkg::COORD_WIDTH_DEF;
	localparam int   PW               = CW + 2;
	localparam logic FUNC_START       = mer_pkg::FUNC_START;
	localparam logic FUNC_STEP        = ~mer_pkg::FUNC_START;
	localparam int   TOTAL_ITEMS      = 160;
	// The last stretch of the random part runs with neither side idling.
	localparam int   CALM_TAIL        = 30;
	localparam int   QUIET_LIMIT      = 2000;
	localparam int   HOLD_AFTER_BEATS = 100;
	localparam int   HOLD_CYCLES      = 80;
	localparam int   DRAIN_CYCLES     = 40;
	localparam int   MAX_REPORTS      = 10;

	typedef struct packed {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic [1:0]           quadrant;
		logic                 last_of_step;
		logic                 finished;
	} pixel_beat_t;

	// How a directed row is checked: by the behavioural model, as a row that
	// must give no pixels, or against four pixels typed into the table.
	typedef enum logic [1:0] {
		BY_MODEL,
		NO_PIXELS,
		AT_POINTS
	} row_check_t;

	typedef struct {
		logic          func;
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [CW-2:0] rx;
		logic [CW-2:0] ry;
		row_check_t    check;
		int            north_x;
		int            north_y;
		int            south_x;
		int            south_y;
		bit            fin;
	} stim_row_t;

	// Typed rows all sit on the first point of an ellipse, where x is zero, so
	// the (+x,-y) and (-x,-y) pixels coincide ("north"), as do the (-x,+y) and
	// (+x,+y) pixels ("south").
	// Columns: func, centre x, centre y, radius x, radius y, check,
	//          north x, north y, south x, south y, finished.
	stim_row_t directed_rows [25] = '{
		// A step straight after reset finds the block idle and is dropped.
		'{FUNC_STEP,     0,    0,   0,   0, NO_PIXELS,    0,    0,    0,    0, 0},
		// Both radii zero: one step plots the centre four times and finishes.
		'{FUNC_START,    0,    0,   0,   0, NO_PIXELS,    0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, AT_POINTS,    0,    0,    0,    0, 1},
		'{FUNC_STEP,     0,    0,   0,   0, NO_PIXELS,    0,    0,    0,    0, 0},
		'{FUNC_START, 1023, 1023,   0,   0, NO_PIXELS,    0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, AT_POINTS, 1023, 1023, 1023, 1023, 1},
		// Largest radii at both corners of the field: the pixel rows reach below
		// zero and above the centre range.
		'{FUNC_START,    0,    0, 511, 511, NO_PIXELS,    0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, AT_POINTS,    0, -511,    0,  511, 0},
		'{FUNC_START, 1023, 1023, 511, 511, NO_PIXELS,    0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, AT_POINTS, 1023,  512, 1023, 1534, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		// Restart in mid-ellipse with a zero vertical radius: a flat ellipse.
		'{FUNC_START,  100,  200,   4,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		// Zero horizontal radius: a vertical line walked wholly in region two.
		'{FUNC_START,  300,   50,   0,   3, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		// A small ordinary ellipse through region one and the switch.
		'{FUNC_START,  512,  512,   5,   3, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0},
		'{FUNC_STEP,     0,    0,   0,   0, BY_MODEL,     0,    0,    0,    0, 0}
	};

	logic clk;
	logic arst_n;

	mer_cmd_if #(.COORD_WIDTH(CW)) cmd_ch ();
	mer_pix_if #(.COORD_WIDTH(CW)) pix_ch ();

	midpoint_ellipse_rasterizer #(
		.COORD_WIDTH(CW)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch.sink),
		.pixel (pix_ch.source)
	);

	// Behavioural state of the rasteriser. All arithmetic is done on 64 bits,
	// so that wrap-around and the sign of the decision value (bit 63) behave
	// exactly as the block is specified to.
	mer_pkg::mer_phase_t el_phase = mer_pkg::PH_IDLE;
	logic [63:0]         pt_x     = '0;
	logic [63:0]         pt_y     = '0;
	logic [63:0]         decision = '0;
	logic [63:0]         sum_dx   = '0;
	logic [63:0]         sum_dy   = '0;
	logic [63:0]         ctr_x    = '0;
	logic [63:0]         ctr_y    = '0;
	logic [63:0]         rad_x    = '0;
	logic [63:0]         rad_y    = '0;

	pixel_beat_t pending_pixels [$];
	int          faults        = 0;
	int          beats_seen    = 0;
	int          items_counted = 0;
	bit          calm          = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void queue_pixel(input logic [63:0] px, input logic [63:0] py,
			input logic [1:0] quad, input bit fin);
		pixel_beat_t b;
		b.x            = px[PW-1:0];
		b.y            = py[PW-1:0];
		b.quadrant     = quad;
		b.last_of_step = (quad == mer_pkg::QUAD_NX_NY);
		b.finished     = fin;
		pending_pixels.push_back(b);
	endfunction

	// Applies one command to the behavioural state and, when keep is set,
	// queues the four pixels that it produces. Returns 0 for a step that the
	// idle block simply drops.
	function automatic bit rasterise_step(input logic func, input logic [CW-1:0] cx,
			input logic [CW-1:0] cy, input logic [CW-2:0] rx, input logic [CW-2:0] ry,
			input bit keep);
		logic [63:0] rx2;
		logic [63:0] ry2;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] x;
		logic [63:0] y;
		bit          fin;
		fin = 1'b0;
		if (func == FUNC_START) begin
			ctr_x    = 64'(cx);
			ctr_y    = 64'(cy);
			rad_x    = 64'(rx);
			rad_y    = 64'(ry);
			rx2      = rad_x * rad_x;
			ry2      = rad_y * rad_y;
			pt_x     = '0;
			pt_y     = rad_y;
			sum_dx   = '0;
			sum_dy   = rx2 * rad_y;
			// Four times the textbook ry^2 - rx^2*ry + rx^2/4.
			decision = 4 * ry2 - 4 * rx2 * rad_y + rx2;
			el_phase = mer_pkg::PH_ONE;
			return 1'b1;
		end
		if (el_phase == mer_pkg::PH_IDLE)
			return 1'b0;

		rx2 = rad_x * rad_x;
		ry2 = rad_y * rad_y;

		// Slope has reached -1: recompute the decision at the midpoint
		// (x + 1/2, y - 1), again scaled by four.
		if (el_phase == mer_pkg::PH_ONE && !(sum_dx < sum_dy)) begin
			a        = 2 * pt_x + 1;
			b        = (pt_y == 0) ? 64'd1 : pt_y - 1;
			decision = ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2;
			el_phase = mer_pkg::PH_TWO;
		end

		x = pt_x;
		y = pt_y;
		if (el_phase == mer_pkg::PH_ONE) begin
			pt_x   = pt_x + 1;
			sum_dx = sum_dx + ry2;
			if (decision[63]) begin
				decision = decision + 8 * sum_dx + 4 * ry2;
			end else begin
				pt_y     = pt_y - 1;
				sum_dy   = sum_dy - rx2;
				decision = decision + 8 * sum_dx + 4 * ry2 - 8 * sum_dy;
			end
		end else if (pt_y == 0) begin
			fin      = 1'b1;
			el_phase = mer_pkg::PH_IDLE;
		end else begin
			pt_y   = pt_y - 1;
			sum_dy = sum_dy - rx2;
			if (!decision[63] && decision != 0) begin
				decision = decision + 4 * rx2 - 8 * sum_dy;
			end else begin
				pt_x     = pt_x + 1;
				sum_dx   = sum_dx + ry2;
				decision = decision + 8 * sum_dx - 8 * sum_dy + 4 * rx2;
			end
		end

		if (keep) begin
			queue_pixel(ctr_x + x, ctr_y - y, mer_pkg::QUAD_PX_NY, fin);
			queue_pixel(ctr_x - x, ctr_y + y, mer_pkg::QUAD_NX_PY, fin);
			queue_pixel(ctr_x + x, ctr_y + y, mer_pkg::QUAD_PX_PY, fin);
			queue_pixel(ctr_x - x, ctr_y - y, mer_pkg::QUAD_NX_NY, fin);
		end
		return 1'b1;
	endfunction

	// Offers one command beat, holds it until the block takes it, then updates
	// the behavioural state at that very edge. Ready is looked at on the falling edge
	// before each rising edge, where it already shows what the edge will see. Valid
	// is left high so that a following beat can go out back to back.
	task automatic send_item(input logic func, input logic [CW-1:0] cx,
			input logic [CW-1:0] cy, input logic [CW-2:0] rx, input logic [CW-2:0] ry,
			input bit keep);
		bit took;
		cmd_ch.valid    <= 1'b1;
		cmd_ch.func     <= func;
		cmd_ch.center_x <= cx;
		cmd_ch.center_y <= cy;
		cmd_ch.radius_x <= rx;
		cmd_ch.radius_y <= ry;
		do begin
			@(negedge clk);
			took = cmd_ch.ready;
			@(posedge clk);
		end while (!took);
		void'(rasterise_step(func, cx, cy, rx, ry, keep));
		items_counted++;
		if (items_counted >= TOTAL_ITEMS - CALM_TAIL)
			calm = 1'b1;
	endtask

	// Now and then the sender goes quiet for a burst of cycles.
	task automatic pause();
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random part. Most of it is whole ellipses with small radii, walked to the
	// end and sometimes past it. Some ellipses are cut short by a fresh start,
	// a few use radii up to the full range for a handful of steps, and the
	// rest is noise with every field random.
	task automatic random_ellipses();
		int            shape;
		int            limit;
		int            steps;
		logic [CW-2:0] rx;
		logic [CW-2:0] ry;
		while (items_counted < TOTAL_ITEMS) begin
			shape = $urandom_range(0, 9);
			if (shape == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_item(1'($urandom), CW'($urandom), CW'($urandom),
						(CW-1)'($urandom), (CW-1)'($urandom), 1'b1);
					pause();
				end
			end else begin
				if (shape == 1) begin
					rx    = (CW-1)'($urandom);
					ry    = (CW-1)'($urandom);
					limit = $urandom_range(3, 12);
				end else begin
					rx    = (CW-1)'($urandom_range(0, 12));
					ry    = (CW-1)'($urandom_range(0, 12));
					limit = (shape == 2) ? $urandom_range(1, 8) : 200;
				end
				send_item(FUNC_START, CW'($urandom), CW'($urandom), rx, ry, 1'b1);
				pause();
				steps = 0;
				while (el_phase != mer_pkg::PH_IDLE && steps < limit) begin
					send_item(FUNC_STEP, CW'($urandom), CW'($urandom),
						(CW-1)'($urandom), (CW-1)'($urandom), 1'b1);
					pause();
					steps++;
				end
				// Steps after the end of an ellipse must be swallowed.
				if (el_phase == mer_pkg::PH_IDLE) begin
					repeat ($urandom_range(0, 2)) begin
						send_item(FUNC_STEP, CW'($urandom), CW'($urandom),
							(CW-1)'($urandom), (CW-1)'($urandom), 1'b1);
						pause();
					end
				end
			end
		end
	endtask

	initial begin : stimulus
		stim_row_t row;
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.func     = FUNC_START;
		cmd_ch.center_x = '0;
		cmd_ch.center_y = '0;
		cmd_ch.radius_x = '0;
		cmd_ch.radius_y = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: typed rows queue their pixels by hand, though the
		// behavioural state still follows every command.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_item(row.func, row.cx, row.cy, row.rx, row.ry, row.check == BY_MODEL);
			if (row.check == AT_POINTS) begin
				queue_pixel(64'(row.north_x), 64'(row.north_y), mer_pkg::QUAD_PX_NY, row.fin);
				queue_pixel(64'(row.south_x), 64'(row.south_y), mer_pkg::QUAD_NX_PY, row.fin);
				queue_pixel(64'(row.south_x), 64'(row.south_y), mer_pkg::QUAD_PX_PY, row.fin);
				queue_pixel(64'(row.north_x), 64'(row.north_y), mer_pkg::QUAD_NX_NY, row.fin);
			end
			pause();
		end

		random_ellipses();
		cmd_ch.valid <= 1'b0;

		// Let the last pixels drain, then leave room for any stray beat.
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Pixel receiver. Each beat taken is compared with the oldest pixel still
	// owed. The channel is looked at on the falling edge before each edge, where
	// the block's registered outputs already hold what the edge will see. Ready is
	// dropped in random bursts, and once, well into the run, for a long
	// stretch so that the job queue fills and the command side stalls.
	initial begin : pixel_sink
		int          stall;
		bit          held;
		bit          took;
		pixel_beat_t got;
		pixel_beat_t want;
		stall        = 0;
		held         = 1'b0;
		pix_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			took             = arst_n && pix_ch.valid && pix_ch.ready;
			got.x            = pix_ch.pixel_x;
			got.y            = pix_ch.pixel_y;
			got.quadrant     = pix_ch.quadrant;
			got.last_of_step = pix_ch.last_of_step;
			got.finished     = pix_ch.finished;
			@(posedge clk);
			if (took) begin
				beats_seen++;
				if (pending_pixels.size() == 0) begin
					faults++;
					if (faults <= MAX_REPORTS)
						$display("%0t: pixel beat with none owed: x=%0d y=%0d q=%0d",
							$realtime, got.x, got.y, got.quadrant,
							" last=%0b fin=%0b", got.last_of_step, got.finished);
				end else begin
					want = pending_pixels.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.quadrant !== want.quadrant
							|| got.last_of_step !== want.last_of_step
							|| got.finished !== want.finished) begin
						faults++;
						if (faults <= MAX_REPORTS)
							$display("%0t: pixel mismatch: expected x=%0d y=%0d q=%0d last=%0b ",
								$realtime, want.x, want.y, want.quadrant, want.last_of_step,
								"fin=%0b, got x=%0d y=%0d q=%0d last=%0b fin=%0b",
								want.finished, got.x, got.y, got.quadrant, got.last_of_step,
								got.finished);
					end
				end
			end
			if (!held && beats_seen >= HOLD_AFTER_BEATS) begin
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 13);
			end
			if (stall > 0) begin
				stall--;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	// Ends the run if neither channel moves a beat for too long. Both channels
	// are looked at on the falling edge before each rising edge.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
